// ===== rtl/trc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the touch report calibrator.
// No dependencies; used by trc_axis_unit and the top level.
package trc_pkg;

  // width of the signed accumulator holding p*x + q*y + 2*r
  localparam int unsigned AccW = 67;
  localparam int unsigned CoefW = 48;
  localparam int unsigned PosW = 16;

  localparam logic [7:0] StTouch = 8'h81;
  localparam logic [7:0] StRelease = 8'h80;
  localparam logic [5:0] LenMove = 6'd5;
  localparam logic [5:0] LenUp = 6'd6;

  localparam logic [1:0] EvDown = 2'd0;
  localparam logic [1:0] EvMove = 2'd1;
  localparam logic [1:0] EvUp = 2'd2;

  localparam logic [3:0] RegCoefA = 4'd0;
  localparam logic [3:0] RegCoefB = 4'd1;
  localparam logic [3:0] RegCoefC = 4'd2;
  localparam logic [3:0] RegCoefD = 4'd3;
  localparam logic [3:0] RegCoefE = 4'd4;
  localparam logic [3:0] RegCoefF = 4'd5;
  localparam logic [3:0] RegDivisor = 4'd6;
  localparam logic [3:0] RegCalibEn = 4'd7;

  // axis unit sequencer
  typedef enum logic [2:0] {
    U_IDLE, U_DABS, U_ACCX, U_ACCY, U_ADDR, U_NABS, U_DIV, U_FIN
  } unit_state_t;

  // top level sequencer
  typedef enum logic [1:0] {
    T_IDLE, T_CALC_X, T_CALC_Y, T_EMIT
  } top_state_t;

  // status returned by the axis unit
  typedef struct packed {
    logic             done;
    logic [PosW-1:0]  pos;
  } unit_res_t;

endpackage

// ===== rtl/touch_report_calibrate_track_top.sv =====
`timescale 1ns / 1ps
// Touch report calibrator and contact tracker, top level.
// Uses trc_pkg and trc_axis_unit.

// One report is taken at a time. A rejected report is dropped in the cycle of
// its transfer; one that passes its raw coordinates through goes straight to
// the emit state. A calibrated report runs the shared axis unit twice, once
// per axis (32 multiply bits, 65 divide bits, setup, rounding and the
// hand-off, the multiply and divide on one 67-bit adder). A finished result
// sits in the output register while the next report is taken.
module touch_report_calibrate_track_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_report_length,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_y_low,
  input  logic [7:0]  in_y_high,
  input  logic [7:0]  in_x_low,
  input  logic [7:0]  in_x_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y
);

  logic [47:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r, coef_e_r, coef_f_r, div_r;
  logic        cal_en_r;

  trc_pkg::top_state_t state_r, state_nxt;
  logic [15:0] x_r, x_nxt, y_r, y_nxt, px_r, px_nxt, py_r, py_nxt;
  logic        rel_r, rel_nxt, start_r, start_nxt;
  logic        contact_r, contact_nxt;
  logic [15:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;

  logic [15:0] raw_x, raw_y;
  logic        rpt_ok, do_cal, emit_fire, axis_y;
  trc_pkg::unit_res_t u_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      coef_c_r <= '0;
      coef_d_r <= '0;
      coef_e_r <= '0;
      coef_f_r <= '0;
      div_r <= '0;
      cal_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trc_pkg::RegCoefA:   coef_a_r <= cfg_wdata;
        trc_pkg::RegCoefB:   coef_b_r <= cfg_wdata;
        trc_pkg::RegCoefC:   coef_c_r <= cfg_wdata;
        trc_pkg::RegCoefD:   coef_d_r <= cfg_wdata;
        trc_pkg::RegCoefE:   coef_e_r <= cfg_wdata;
        trc_pkg::RegCoefF:   coef_f_r <= cfg_wdata;
        trc_pkg::RegDivisor: div_r <= cfg_wdata;
        trc_pkg::RegCalibEn: cal_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // report decode
  assign raw_x = {in_x_high, in_x_low};
  assign raw_y = {in_y_high, in_y_low};
  assign rpt_ok = (in_report_length == trc_pkg::LenMove || in_report_length == trc_pkg::LenUp)
               && (in_status_byte == trc_pkg::StTouch || in_status_byte == trc_pkg::StRelease);
  assign do_cal = cal_en_r && (div_r != '0) && (raw_x != '0) && (raw_y != '0);
  assign in_ready = (state_r == trc_pkg::T_IDLE);
  assign emit_fire = (state_r == trc_pkg::T_EMIT) && (!out_valid_r || out_ready);
  assign axis_y = (state_r == trc_pkg::T_CALC_Y);

  trc_axis_unit u_axis (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .coef_p  (axis_y ? coef_d_r : coef_a_r),
    .coef_q  (axis_y ? coef_e_r : coef_b_r),
    .coef_r  (axis_y ? coef_f_r : coef_c_r),
    .divisor (div_r),
    .raw_x   (x_r),
    .raw_y   (y_r),
    .res     (u_res)
  );

  // sequencer, tracking and output register
  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    px_nxt = px_r;
    py_nxt = py_r;
    rel_nxt = rel_r;
    start_nxt = 1'b0;
    contact_nxt = contact_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt = kind_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    unique case (state_r)
      trc_pkg::T_IDLE: begin
        if (in_valid && rpt_ok) begin
          x_nxt = raw_x;
          y_nxt = raw_y;
          px_nxt = raw_x;
          py_nxt = raw_y;
          rel_nxt = (in_report_length == trc_pkg::LenUp)
                 || (in_status_byte == trc_pkg::StRelease);
          if (do_cal) begin
            start_nxt = 1'b1;
            state_nxt = trc_pkg::T_CALC_X;
          end else begin
            state_nxt = trc_pkg::T_EMIT;
          end
        end
      end
      trc_pkg::T_CALC_X: begin
        if (u_res.done) begin
          px_nxt = u_res.pos;
          start_nxt = 1'b1;
          state_nxt = trc_pkg::T_CALC_Y;
        end
      end
      trc_pkg::T_CALC_Y: begin
        if (u_res.done) begin
          py_nxt = u_res.pos;
          state_nxt = trc_pkg::T_EMIT;
        end
      end
      trc_pkg::T_EMIT: begin
        if (emit_fire) begin
          state_nxt = trc_pkg::T_IDLE;
          ox_nxt = px_r;
          oy_nxt = py_r;
          if (rel_r) begin
            contact_nxt = 1'b0;
            last_x_nxt = '0;
            last_y_nxt = '0;
            kind_nxt = trc_pkg::EvUp;
            out_valid_nxt = 1'b1;
          end else if (!contact_r) begin
            contact_nxt = 1'b1;
            last_x_nxt = px_r;
            last_y_nxt = py_r;
            kind_nxt = trc_pkg::EvDown;
            out_valid_nxt = 1'b1;
          end else if (last_x_r != px_r || last_y_r != py_r) begin
            last_x_nxt = px_r;
            last_y_nxt = py_r;
            kind_nxt = trc_pkg::EvMove;
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = trc_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trc_pkg::T_IDLE;
      start_r <= 1'b0;
      contact_r <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      contact_r <= contact_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    rel_r <= rel_nxt;
    kind_r <= kind_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_pos_x = ox_r;
  assign out_pos_y = oy_r;

`ifndef NO_ASSERTIONS
  // the axis unit only finishes while the sequencer waits on it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    u_res.done |-> (state_r == trc_pkg::T_CALC_X || state_r == trc_pkg::T_CALC_Y))
    else $error("axis unit done outside a calc state");

  // a release always drops the tracked contact
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && rel_r) |=> (!contact_r && last_x_r == '0 && last_y_r == '0))
    else $error("release did not clear tracking");

  // without a contact the recorded position stays at zero
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !contact_r |-> (last_x_r == '0 && last_y_r == '0))
    else $error("stale position with no contact");
`endif

endmodule

// ===== rtl/trc_axis_unit.sv =====
`timescale 1ns / 1ps
// One-axis affine mapper: shift-add multiply, restoring divide, rounding.
// Multiply, divide and sign steps share one 67-bit add/subtract unit. Uses trc_pkg.
module trc_axis_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [47:0]            coef_p,
  input  logic [47:0]            coef_q,
  input  logic [47:0]            coef_r,
  input  logic [47:0]            divisor,
  input  logic [15:0]            raw_x,
  input  logic [15:0]            raw_y,
  output trc_pkg::unit_res_t     res
);

  trc_pkg::unit_state_t state_r, state_nxt;
  logic [66:0] acc_r, acc_nxt;
  logic [66:0] m_r, m_nxt;
  logic [15:0] mul_r, mul_nxt;
  logic [47:0] dm_r, dm_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [15:0] pos_r, pos_nxt;

  logic [66:0] op_a, op_b, sum;
  logic        op_sub;
  logic [48:0] rem_sh;
  logic [16:0] q_rnd;
  logic        rnd;

  // shared adder/subtractor
  assign sum = op_a + (op_sub ? ~op_b : op_b) + {66'd0, op_sub};
  assign rem_sh = {rem_r, acc_r[64]};
  assign rnd = ~sum[66];
  assign q_rnd = q_r + {16'd0, rnd};

  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r;
    m_nxt = m_r;
    mul_nxt = mul_r;
    dm_nxt = dm_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    pos_nxt = pos_r;
    op_a = '0;
    op_b = '0;
    op_sub = 1'b0;
    unique case (state_r)
      trc_pkg::U_IDLE: begin
        if (start) begin
          state_nxt = trc_pkg::U_DABS;
        end
      end
      // magnitude of the divider; load x multiply
      trc_pkg::U_DABS: begin
        op_b = {{19{divisor[47]}}, divisor};
        op_sub = 1'b1;
        dm_nxt = divisor[47] ? sum[47:0] : divisor;
        acc_nxt = '0;
        m_nxt = {{19{coef_p[47]}}, coef_p};
        mul_nxt = raw_x;
        cnt_nxt = 7'd15;
        state_nxt = trc_pkg::U_ACCX;
      end
      // shift-add multiply, one multiplier bit per cycle
      trc_pkg::U_ACCX, trc_pkg::U_ACCY: begin
        op_a = acc_r;
        op_b = mul_r[0] ? m_r : '0;
        acc_nxt = sum;
        m_nxt = {m_r[65:0], 1'b0};
        mul_nxt = {1'b0, mul_r[15:1]};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          cnt_nxt = 7'd15;
          if (state_r == trc_pkg::U_ACCX) begin
            m_nxt = {{19{coef_q[47]}}, coef_q};
            mul_nxt = raw_y;
            state_nxt = trc_pkg::U_ACCY;
          end else begin
            state_nxt = trc_pkg::U_ADDR;
          end
        end
      end
      // offset term counts twice
      trc_pkg::U_ADDR: begin
        op_a = acc_r;
        op_b = {{18{coef_r[47]}}, coef_r, 1'b0};
        acc_nxt = sum;
        state_nxt = trc_pkg::U_NABS;
      end
      // numerator magnitude and result sign
      trc_pkg::U_NABS: begin
        op_b = acc_r;
        op_sub = 1'b1;
        acc_nxt = acc_r[66] ? sum : acc_r;
        neg_nxt = acc_r[66] ^ divisor[47];
        rem_nxt = '0;
        q_nxt = '0;
        cnt_nxt = 7'd64;
        state_nxt = trc_pkg::U_DIV;
      end
      // restoring divide, numerator bits 64 down to 0
      trc_pkg::U_DIV: begin
        op_a = {18'd0, rem_sh};
        op_b = {19'd0, dm_r};
        op_sub = 1'b1;
        rem_nxt = sum[66] ? rem_sh[47:0] : sum[47:0];
        q_nxt = q_r[16] ? q_r : {q_r[15:0], ~sum[66]};
        acc_nxt = {acc_r[65:0], 1'b0};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          state_nxt = trc_pkg::U_FIN;
        end
      end
      // round half away from zero, clamp to 1..65535
      trc_pkg::U_FIN: begin
        op_a = {18'd0, rem_r, 1'b0};
        op_b = {19'd0, dm_r};
        op_sub = 1'b1;
        if (neg_r || (q_r == 17'd0 && !rnd)) begin
          pos_nxt = 16'd1;
        end else if (q_r[16] || q_rnd[16]) begin
          pos_nxt = 16'hFFFF;
        end else begin
          pos_nxt = q_rnd[15:0];
        end
        done_nxt = 1'b1;
        state_nxt = trc_pkg::U_IDLE;
      end
      default: state_nxt = trc_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trc_pkg::U_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    m_r <= m_nxt;
    mul_r <= mul_nxt;
    dm_r <= dm_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    pos_r <= pos_nxt;
  end

  assign res.done = done_r;
  assign res.pos = pos_r;

endmodule
